/* sv/aese_pkg.sv */
// Package for the array edit and sort engine.
// Holds command, status and sequencer state types; no dependencies.
package aese_pkg;

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_DELMAX = 3'd3,
      CMD_SORT   = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS,
      S_INS_WR,
      S_DEL,
      S_DEL_WR,
      S_READ_WAIT,
      S_SCAN,
      S_COMPACT,
      S_SORT_LOAD,
      S_SORT_BASE,
      S_SORT_SCAN,
      S_SWAP_A,
      S_SWAP_B,
      S_DONE
   } state_type;

endpackage

/* sv/aese_seq.sv */
// Sequencer, element memory and shared compare datapath of the engine.
// Depends on aese_pkg.
module aese_seq #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   localparam int AW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  aese_pkg::cmd_type      cmd,
   input  logic [AW-1:0]          idx,
   input  logic [DATA_WIDTH-1:0]  val,
   input  logic                   out_free,
   output logic                   ready,
   output logic                   done,
   output aese_pkg::status_type   status,
   output logic [CW-1:0]          count,
   output logic [DATA_WIDTH-1:0]  rd_value,
   output logic [DATA_WIDTH-1:0]  min_value,
   output logic [DATA_WIDTH-1:0]  max_value
);
   import aese_pkg::*;

   localparam int DW = DATA_WIDTH;

   logic [DW-1:0] mem [CAPACITY];
   logic [DW-1:0] rdata_ff;

   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [DW-1:0] val_ff, val_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [CW-1:0] base_ff, base_in;
   logic [CW-1:0] rdi_ff, rdi_in;
   logic [AW-1:0] best_ff, best_in;
   logic [DW-1:0] best_val_ff, best_val_in;
   logic [DW-1:0] base_val_ff, base_val_in;
   status_type    status_ff, status_in;
   logic [DW-1:0] rd_ff, rd_in;
   logic [DW-1:0] min_ff, min_in;
   logic [DW-1:0] max_ff, max_in;
   logic          pend_ff, pend_in;
   logic          phase_ff, phase_in;

   logic          we;
   logic [AW-1:0] waddr;
   logic [DW-1:0] wdata;
   logic [AW-1:0] raddr;

   logic [CW-1:0] idx_ext, ptr_inc, ptr_dec, base_inc, wr_inc, count_inc, count_dec;
   logic          full, empty, scan_end, gt_max, lt_min, gt_best, ne_max;

   assign idx_ext   = CW'(idx_ff);
   assign ptr_inc   = ptr_ff + CW'(1);
   assign ptr_dec   = ptr_ff - CW'(1);
   assign base_inc  = base_ff + CW'(1);
   assign wr_inc    = wr_ff + CW'(1);
   assign count_inc = count_ff + CW'(1);
   assign count_dec = count_ff - CW'(1);
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign scan_end  = (ptr_ff == count_ff) && !pend_ff;
   assign gt_max    = $signed(rdata_ff) > $signed(max_ff);
   assign lt_min    = $signed(rdata_ff) < $signed(min_ff);
   assign gt_best   = $signed(rdata_ff) > $signed(best_val_ff);
   assign ne_max    = rdata_ff != max_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (start) state_in = S_DISPATCH;
         S_DISPATCH: begin
            case (cmd_ff)
               CMD_INSERT: state_in = (full || idx_ext > count_ff) ? S_SCAN : S_INS;
               CMD_DELETE, CMD_READ: begin
                  if (empty || idx_ext >= count_ff) state_in = S_SCAN;
                  else if (cmd_ff == CMD_READ)     state_in = S_READ_WAIT;
                  else                             state_in = S_DEL;
               end
               CMD_SORT:   state_in = (count_ff < CW'(2)) ? S_SCAN : S_SORT_LOAD;
               default:    state_in = S_SCAN;
            endcase
         end
         S_INS:       state_in = (ptr_ff == idx_ext) ? S_SCAN : S_INS_WR;
         S_INS_WR:    state_in = S_INS;
         S_DEL:       state_in = (ptr_inc >= count_ff) ? S_SCAN : S_DEL_WR;
         S_DEL_WR:    state_in = S_DEL;
         S_READ_WAIT: state_in = S_SCAN;
         S_SCAN:      if (scan_end) state_in = phase_ff ? S_COMPACT : S_DONE;
         S_COMPACT:   if (scan_end) state_in = S_SCAN;
         S_SORT_LOAD: state_in = (base_inc >= count_ff) ? S_SCAN : S_SORT_BASE;
         S_SORT_BASE: state_in = S_SORT_SCAN;
         S_SORT_SCAN: if (scan_end) state_in = S_SWAP_A;
         S_SWAP_A:    state_in = S_SWAP_B;
         S_SWAP_B:    state_in = S_SORT_LOAD;
         S_DONE:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      wr_in       = wr_ff;
      base_in     = base_ff;
      rdi_in      = rdi_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      base_val_in = base_val_ff;
      status_in   = status_ff;
      rd_in       = rd_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      pend_in     = pend_ff;
      phase_in    = phase_ff;
      we          = 1'b0;
      waddr       = ptr_ff[AW-1:0];
      wdata       = rdata_ff;
      raddr       = ptr_ff[AW-1:0];
      ready       = 1'b0;
      done        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ready = 1'b1;
            if (start) begin
               cmd_in    = cmd;
               idx_in    = idx;
               val_in    = val;
               status_in = ST_OK;
               rd_in     = '0;
               phase_in  = 1'b0;
            end
         end
         S_DISPATCH: begin
            ptr_in  = '0;
            pend_in = 1'b0;
            case (cmd_ff)
               CMD_APPEND: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     we       = 1'b1;
                     waddr    = count_ff[AW-1:0];
                     wdata    = val_ff;
                     count_in = count_inc;
                  end
               end
               CMD_INSERT: begin
                  if (full)                   status_in = ST_FULL;
                  else if (idx_ext > count_ff) status_in = ST_RANGE;
                  else                        ptr_in = count_ff;
               end
               CMD_DELETE, CMD_READ: begin
                  if (empty)                   status_in = ST_EMPTY;
                  else if (idx_ext >= count_ff) status_in = ST_RANGE;
                  else begin
                     ptr_in = idx_ext;
                     raddr  = idx_ff;
                  end
               end
               CMD_DELMAX: begin
                  if (empty) status_in = ST_EMPTY;
                  else       phase_in = 1'b1;
               end
               CMD_SORT: base_in = '0;
               default: ;
            endcase
         end
         S_INS: begin
            if (ptr_ff == idx_ext) begin
               we       = 1'b1;
               waddr    = idx_ff;
               wdata    = val_ff;
               count_in = count_inc;
               ptr_in   = '0;
               pend_in  = 1'b0;
            end else begin
               raddr = ptr_dec[AW-1:0];
            end
         end
         S_INS_WR: begin
            we     = 1'b1;
            ptr_in = ptr_dec;
         end
         S_DEL: begin
            if (ptr_inc >= count_ff) begin
               count_in = count_dec;
               ptr_in   = '0;
               pend_in  = 1'b0;
            end else begin
               raddr = ptr_inc[AW-1:0];
            end
         end
         S_DEL_WR: begin
            we     = 1'b1;
            ptr_in = ptr_inc;
         end
         S_READ_WAIT: begin
            rd_in  = rdata_ff;
            ptr_in = '0;
         end
         S_SCAN, S_COMPACT, S_SORT_SCAN: begin
            pend_in = (ptr_ff != count_ff);
            if (ptr_ff != count_ff) begin
               ptr_in = ptr_inc;
               rdi_in = ptr_ff;
            end
            if (pend_ff) begin
               case (state_ff)
                  S_SCAN: begin
                     if (rdi_ff == '0) begin
                        min_in = rdata_ff;
                        max_in = rdata_ff;
                     end else begin
                        if (gt_max) max_in = rdata_ff;
                        if (lt_min) min_in = rdata_ff;
                     end
                  end
                  S_COMPACT: begin
                     if (ne_max) begin
                        we    = 1'b1;
                        waddr = wr_ff[AW-1:0];
                        wr_in = wr_inc;
                     end
                  end
                  default: begin
                     if (gt_best) begin
                        best_val_in = rdata_ff;
                        best_in     = rdi_ff[AW-1:0];
                     end
                  end
               endcase
            end
            if (scan_end) begin
               ptr_in = '0;
               case (state_ff)
                  S_SCAN: begin
                     wr_in    = '0;
                     phase_in = 1'b0;
                     if (empty) begin
                        min_in = '0;
                        max_in = '0;
                     end
                  end
                  S_COMPACT: count_in = wr_ff;
                  default: ;
               endcase
            end
         end
         S_SORT_LOAD: begin
            raddr   = base_ff[AW-1:0];
            ptr_in  = '0;
            pend_in = 1'b0;
         end
         S_SORT_BASE: begin
            base_val_in = rdata_ff;
            best_val_in = rdata_ff;
            best_in     = base_ff[AW-1:0];
            ptr_in      = base_inc;
            pend_in     = 1'b0;
         end
         S_SWAP_A: begin
            we    = 1'b1;
            waddr = best_ff;
            wdata = base_val_ff;
         end
         S_SWAP_B: begin
            we      = 1'b1;
            waddr   = base_ff[AW-1:0];
            wdata   = best_val_ff;
            base_in = base_inc;
         end
         S_DONE: begin
            done = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      ptr_ff      <= ptr_in;
      wr_ff       <= wr_in;
      base_ff     <= base_in;
      rdi_ff      <= rdi_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      base_val_ff <= base_val_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
   end

   assign status    = status_ff;
   assign count     = count_ff;
   assign rd_value  = rd_ff;
   assign min_value = min_ff;
   assign max_value = max_ff;

endmodule

/* sv/array_edit_sort_engine.sv */
// Top level of the array edit and sort engine: stream ports and response register.
// Depends on aese_pkg and aese_seq.
//
// One request runs at a time through a sequencer around an element memory with one write
// port and one registered read port, so every step that moves or inspects an entry costs a
// memory access. Every command passes through accept, dispatch and handoff plus a closing
// min/max scan over all entries. On top of that read adds a memory read, insert and delete
// a read and a write per shifted entry, delete-max a compaction pass that drops every entry
// equal to the maximum and a second scan, and sort a selection pass per base position with
// a swap. Requests are taken again as soon as the result sits in the response register.
module array_edit_sort_engine #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1),
   localparam int REQ_W = ((IDX_W + DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((CNT_W + 3 * DATA_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // index, value
   input  logic [2:0]       req_tuser,  // cmd
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // count, read_value, min_value, max_value
   output logic [1:0]       rsp_tuser   // status
);
   import aese_pkg::*;

   localparam int DW = DATA_WIDTH;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]       rsp_user_ff, rsp_user_in;

   logic             start, seq_ready, seq_done, out_free;
   status_type       seq_status;
   logic [CNT_W-1:0] seq_count;
   logic [DW-1:0]    seq_rd, seq_min, seq_max;

   assign req_tready = seq_ready;
   assign start      = req_tvalid && seq_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   aese_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd_type'(req_tuser)),
      .idx       (req_tdata[IDX_W-1:0]),
      .val       (req_tdata[IDX_W+DW-1:IDX_W]),
      .out_free  (out_free),
      .ready     (seq_ready),
      .done      (seq_done),
      .status    (seq_status),
      .count     (seq_count),
      .rd_value  (seq_rd),
      .min_value (seq_min),
      .max_value (seq_max)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (seq_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({seq_max, seq_min, seq_rd, seq_count});
         rsp_user_in  = seq_status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
